@@ rtl/fptt_pkg.sv @@
// fptt_pkg: shared types, codes and helpers of the frame presentation target table
// used by the engine, the top level and the port checker of the block

package fptt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // command codes
    localparam logic [2:0] CMD_PREPARE        = 3'd0;
    localparam logic [2:0] CMD_DECODED        = 3'd1;
    localparam logic [2:0] CMD_DISCARD_HANDLE = 3'd2;
    localparam logic [2:0] CMD_DISCARD_PTS    = 3'd3;
    localparam logic [2:0] CMD_RESET          = 3'd4;

    // action codes
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_DROP     = 2'd1;
    localparam logic [1:0] ACT_SCHEDULE = 2'd2;

    // event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_NONMONO  = 3'd1;
    localparam logic [2:0] EV_MISSING  = 3'd2;
    localparam logic [2:0] EV_EXPIRED  = 3'd3;
    localparam logic [2:0] EV_FUTURE   = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SUBMIT_LEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FUTURE  = 2'd1;

    localparam logic [31:0] SUBMIT_LEAD_RESET = 32'd0;
    localparam logic [31:0] MAX_FUTURE_RESET  = 32'd50000001;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [63:0] pts_us;
        logic signed [63:0] time_ns;
        logic               plan_schedules;
        logic               plan_discontinuity;
        logic [31:0]        handle_in;
    } item_t;

    typedef struct packed {
        logic [31:0]        handle_out;
        logic [1:0]         action;
        logic [2:0]         event_res;
        logic signed [63:0] target_time_ns;
        logic signed [63:0] target_lead_ns;
        logic [3:0]         pending_count;
    } result_t;

    typedef struct packed {
        logic [31:0] submit_lead_ns;
        logic [31:0] max_future_lead_ns;
    } cfg_t;

    // one slot of the entry ram
    typedef struct packed {
        logic [31:0] handle;
        logic [63:0] pts;
        logic [63:0] target;
    } entry_t;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        idx_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        idx_dec = (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

endpackage

@@ rtl/fptt_ram.sv @@
// fptt_ram: generic simple dual-port ram, one write and one registered read port
// no package dependency

module fptt_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 160
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/fptt_engine.sv @@
// fptt_engine: command sequencer, slot valid bits, ring pointers and entry ram scan
// depends on fptt_pkg and fptt_ram

module fptt_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  fptt_pkg::item_t  item,
    input  fptt_pkg::cfg_t   cfg,
    output logic             res_valid,
    input  logic             res_ready,
    output fptt_pkg::result_t res
);

    import fptt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_LEAD  = 3'd3;
    localparam logic [2:0] S_CLASS = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]             state_reg, state_next;
    item_t                  item_reg, item_next;
    result_t                res_reg, res_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       write_slot_reg, write_slot_next;
    logic [31:0]            next_handle_reg, next_handle_next;
    logic [63:0]            last_pts_reg, last_pts_next;
    logic                   have_last_reg, have_last_next;
    logic                   nonmono_reg, nonmono_next;
    logic                   by_handle_reg, by_handle_next;
    logic                   scan_down_reg, scan_down_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]       left_reg, left_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic [63:0]            target_reg, target_next;

    logic                   ram_we, ram_re;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    entry_t                 ram_wdata, ram_rentry;
    logic [$bits(entry_t)-1:0] ram_rdata;
    logic                   hit;

    fptt_ram #(
        .DEPTH(TABLE_DEPTH),
        .WIDTH($bits(entry_t))
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign ram_rentry = entry_t'(ram_rdata);

    // compare of the slot read in the previous cycle
    assign hit = chk_valid_reg && valid_reg[chk_idx_reg] &&
                 (by_handle_reg ? (ram_rentry.handle == item_reg.handle_in)
                                : (ram_rentry.pts == 64'(item_reg.pts_us)));

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);

    always_comb
    begin
        res = res_reg;
        res.pending_count = 4'(count_reg);
    end

    always_comb
    begin
        logic [IDX_W-1:0]       slot_v;
        logic [TABLE_DEPTH-1:0] vbits_v;
        logic [CNT_W-1:0]       cnt_v;
        logic                   finish_v;
        logic                   found_v;
        logic signed [63:0]     lead_v;

        slot_v   = write_slot_reg;
        vbits_v  = valid_reg;
        cnt_v    = count_reg;
        finish_v = 1'b0;
        found_v  = 1'b0;
        lead_v   = $signed(target_reg);

        state_next       = state_reg;
        item_next        = item_reg;
        res_next         = res_reg;
        valid_next       = valid_reg;
        count_next       = count_reg;
        write_slot_next  = write_slot_reg;
        next_handle_next = next_handle_reg;
        last_pts_next    = last_pts_reg;
        have_last_next   = have_last_reg;
        nonmono_next     = nonmono_reg;
        by_handle_next   = by_handle_reg;
        scan_down_next   = scan_down_reg;
        scan_idx_next    = scan_idx_reg;
        left_next        = left_reg;
        chk_valid_next   = chk_valid_reg;
        chk_idx_next     = chk_idx_reg;
        target_next      = target_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = write_slot_reg;
        ram_wdata = '0;
        ram_raddr = scan_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next       = '0;
                chk_valid_next = 1'b0;
                left_next      = CNT_W'(TABLE_DEPTH);
                nonmono_next   = have_last_reg &&
                                 (item_reg.pts_us <= $signed(last_pts_reg));
                state_next     = S_DONE;
                case (item_reg.cmd)
                    CMD_PREPARE:
                    begin
                        if (item_reg.plan_schedules)
                        begin
                            if (item_reg.plan_discontinuity)
                            begin
                                slot_v         = '0;
                                vbits_v        = '0;
                                cnt_v          = '0;
                                have_last_next = 1'b0;
                            end
                            ram_we           = 1'b1;
                            ram_waddr        = slot_v;
                            ram_wdata.handle = next_handle_reg;
                            ram_wdata.pts    = 64'(item_reg.pts_us);
                            ram_wdata.target = 64'(item_reg.time_ns);
                            count_next       = vbits_v[slot_v] ? cnt_v : cnt_v + 1'b1;
                            valid_next       = vbits_v;
                            valid_next[slot_v] = 1'b1;
                            write_slot_next  = idx_inc(slot_v);
                            // handle wraps and never takes zero
                            next_handle_next = (next_handle_reg == 32'hFFFF_FFFF)
                                               ? 32'd1 : next_handle_reg + 32'd1;
                            res_next.handle_out = next_handle_reg;
                        end
                    end
                    CMD_DECODED, CMD_DISCARD_PTS:
                    begin
                        by_handle_next = 1'b0;
                        scan_down_next = 1'b1;
                        scan_idx_next  = idx_dec(write_slot_reg);
                        state_next     = S_SCAN;
                    end
                    CMD_DISCARD_HANDLE:
                    begin
                        if (item_reg.handle_in != 32'd0)
                        begin
                            by_handle_next = 1'b1;
                            scan_down_next = 1'b0;
                            scan_idx_next  = '0;
                            state_next     = S_SCAN;
                        end
                    end
                    CMD_RESET:
                    begin
                        valid_next      = '0;
                        count_next      = '0;
                        write_slot_next = '0;
                        last_pts_next   = '0;
                        have_last_next  = 1'b0;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    valid_next[chk_idx_reg] = 1'b0;
                    count_next     = count_reg - 1'b1;
                    target_next    = ram_rentry.target;
                    chk_valid_next = 1'b0;
                    finish_v       = 1'b1;
                    found_v        = 1'b1;
                end
                else if (left_reg == '0)
                begin
                    chk_valid_next = 1'b0;
                    finish_v       = 1'b1;
                end
                else
                begin
                    ram_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg;
                    left_next      = left_reg - 1'b1;
                    scan_idx_next  = scan_down_reg ? idx_dec(scan_idx_reg)
                                                   : idx_inc(scan_idx_reg);
                end

                if (finish_v)
                begin
                    state_next = S_DONE;
                    if (item_reg.cmd == CMD_DECODED)
                    begin
                        if (nonmono_reg)
                        begin
                            res_next.action    = ACT_DROP;
                            res_next.event_res = EV_NONMONO;
                        end
                        else if (!found_v)
                        begin
                            res_next.event_res = EV_MISSING;
                        end
                        else
                        begin
                            state_next = S_LEAD;
                        end
                    end
                end
            end

            S_LEAD:
            begin
                res_next.target_lead_ns = $signed(target_reg - 64'(item_reg.time_ns));
                state_next = S_CLASS;
            end

            S_CLASS:
            begin
                lead_v         = res_reg.target_lead_ns;
                last_pts_next  = 64'(item_reg.pts_us);
                have_last_next = 1'b1;
                if (lead_v < $signed({32'd0, cfg.submit_lead_ns}))
                begin
                    res_next.event_res = EV_EXPIRED;
                end
                else if (lead_v > $signed({32'd0, cfg.max_future_lead_ns}))
                begin
                    res_next.event_res = EV_FUTURE;
                end
                else
                begin
                    res_next.action         = ACT_SCHEDULE;
                    res_next.target_time_ns = $signed(target_reg);
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            count_reg       <= '0;
            write_slot_reg  <= '0;
            next_handle_reg <= 32'd1;
            last_pts_reg    <= '0;
            have_last_reg   <= 1'b0;
            chk_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            count_reg       <= count_next;
            write_slot_reg  <= write_slot_next;
            next_handle_reg <= next_handle_next;
            last_pts_reg    <= last_pts_next;
            have_last_reg   <= have_last_next;
            chk_valid_reg   <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        res_reg       <= res_next;
        nonmono_reg   <= nonmono_next;
        by_handle_reg <= by_handle_next;
        scan_down_reg <= scan_down_next;
        scan_idx_reg  <= scan_idx_next;
        left_reg      <= left_next;
        chk_idx_reg   <= chk_idx_next;
        target_reg    <= target_next;
    end

endmodule

@@ rtl/frame_presentation_target_table_top.sv @@
// frame_presentation_target_table_top: top level with config registers and result register
// depends on fptt_pkg and fptt_engine
//
//   channel   direction  handshake                 word
//   item      sink       item_valid / item_ready   fptt_pkg::item_t
//   result    source     result_valid / result_ready fptt_pkg::result_t
//   cfg       sink       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// prepare, reset, unused commands and a discard by handle zero pass from the exec state
// straight to done; other discards and decoded words first scan the entry ram one slot
// per cycle through its single registered read port, and a decoded hit that is not late
// then passes the lead and classify states; result_valid comes from the result register
// the engine takes the next item word in the cycle after its result moves on
// reset (rst_n, async) clears every slot valid bit at once, no clearing pass
// a finished result sits in the result register, so a stalled sink holds at
// most one word there while the engine may already take the next item word

module frame_presentation_target_table_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  fptt_pkg::item_t                       item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output fptt_pkg::result_t                     result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fptt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [31:0]                           cfg_data
);

    import fptt_pkg::*;

    cfg_t    cfg_reg;
    logic    out_valid_reg;
    result_t out_word_reg;

    logic    res_valid;
    logic    res_ready;
    result_t res;

    // the user must see that config is written only while idle; the block does not check it, so it is always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.submit_lead_ns     <= SUBMIT_LEAD_RESET;
            cfg_reg.max_future_lead_ns <= MAX_FUTURE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SUBMIT_LEAD: cfg_reg.submit_lead_ns     <= cfg_data;
                REG_MAX_FUTURE:  cfg_reg.max_future_lead_ns <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    fptt_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result register: loads when empty or being drained this cycle
    assign res_ready = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_word_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule

@@ rtl/fptt_checker.sv @@
// fptt_checker: port-level assertions for the target table, bound to the top level
// depends on fptt_pkg and frame_presentation_target_table_top

module fptt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input fptt_pkg::result_t result
);

    import fptt_pkg::*;

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // one item at a time: an accepted item closes the input for the next cycle
    a_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while previous still in work");

    // a scheduled result carries no event and a non-negative lead
    a_schedule_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.action == ACT_SCHEDULE |->
            result.event_res == EV_NONE && !result.target_lead_ns[63])
        else $error("scheduled result with event or negative lead");

    // a stored prepare leaves at least one pending entry and no decode outcome
    a_prepare_stored: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.handle_out != 32'd0 |->
            result.action == ACT_NONE && result.event_res == EV_NONE &&
            (TABLE_DEPTH > 15 || result.pending_count != 4'd0))
        else $error("prepare result inconsistent");

endmodule

bind frame_presentation_target_table_top fptt_checker u_fptt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
);

@@ dv/frame_presentation_target_table_top_tb.sv @@
// self-checking testbench for frame_presentation_target_table_top: directed and random words
// with a per-word predictor of the target table; depends on fptt_pkg and the rtl top level

module frame_presentation_target_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fptt_pkg::*;

    // cycles the block may still spend on a word after its result is out
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    // hard stop for a hung run
    localparam int CYCLE_LIMIT = 500000;
    // size of the 3-bit command space, codes above CMD_RESET are spare
    localparam int CMD_SPACE = 8;
    // nominal frame spacing of the random stream
    localparam longint FRAME_US = 16667;
    localparam longint FRAME_NS = 16666667;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    item_t                item = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    frame_presentation_target_table_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // predicted table state, kept in step with every accepted word
    // ------------------------------------------------------------------
    bit          slot_live   [TABLE_DEPTH];
    logic [31:0] slot_handle [TABLE_DEPTH];
    logic [63:0] slot_pts    [TABLE_DEPTH];
    logic [63:0] slot_target [TABLE_DEPTH];
    int unsigned fill_slot;
    int unsigned live_count;
    logic [31:0] handle_ctr;
    logic [63:0] newest_pts;
    bit          newest_seen;

    // predicted register contents
    logic [31:0] lead_floor;
    logic [31:0] lead_ceiling;

    // result words still to come, oldest first
    result_t     predicted_results [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    // when set neither side idles
    bit          no_idle = 1'b0;

    // random stream bookkeeping: prepared timestamps and their targets, oldest first
    longint      pool_pts [$];
    longint      pool_tgt [$];
    longint      stream_pts = 0;
    longint      stream_ns = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void clear_slots();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            slot_live[i]   = 1'b0;
            slot_handle[i] = '0;
            slot_pts[i]    = '0;
            slot_target[i] = '0;
        end
        fill_slot  = 0;
        live_count = 0;
    endfunction

    function automatic void reset_table_model();
        clear_slots();
        handle_ctr   = 32'd1;
        newest_pts   = '0;
        newest_seen  = 1'b0;
        lead_floor   = SUBMIT_LEAD_RESET;
        lead_ceiling = MAX_FUTURE_RESET;
    endfunction

    // remove the most recently written live slot with this timestamp
    function automatic bit take_newest(input logic [63:0] pts, output logic [63:0] target);
        int unsigned idx;
        target = '0;
        for (int off = 0; off < TABLE_DEPTH; off++)
        begin
            idx = (fill_slot + TABLE_DEPTH - 1 - off) % TABLE_DEPTH;
            if (slot_live[idx] && slot_pts[idx] == pts)
            begin
                slot_live[idx] = 1'b0;
                if (live_count > 0)
                    live_count--;
                target = slot_target[idx];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] store_slot(input logic [63:0] pts, input logic [63:0] target);
        logic [31:0] h;
        int unsigned slot;
        h = handle_ctr;
        slot = fill_slot % TABLE_DEPTH;
        handle_ctr = handle_ctr + 32'd1;
        if (handle_ctr == '0)
            handle_ctr = 32'd1;
        if (!slot_live[slot])
            live_count++;
        slot_live[slot]   = 1'b1;
        slot_handle[slot] = h;
        slot_pts[slot]    = pts;
        slot_target[slot] = target;
        fill_slot = (slot + 1) % TABLE_DEPTH;
        return h;
    endfunction

    // expected result word of one accepted item word, updates the predicted state
    function automatic result_t predict_table_step(input item_t w);
        result_t     r;
        logic [63:0] tgt;
        logic [63:0] lead;
        bit          found;
        bit          removed;
        r = '0;
        case (w.cmd)
            CMD_PREPARE:
            begin
                // a frame the planner does not schedule leaves everything alone
                if (w.plan_schedules)
                begin
                    if (w.plan_discontinuity)
                    begin
                        clear_slots();
                        newest_seen = 1'b0;
                    end
                    r.handle_out = store_slot(w.pts_us, w.time_ns);
                end
            end
            CMD_DECODED:
            begin
                if (newest_seen && $signed(w.pts_us) <= $signed(newest_pts))
                begin
                    // late frame: dropped, its entry goes too, last timestamp kept
                    r.action    = ACT_DROP;
                    r.event_res = EV_NONMONO;
                    found = take_newest(w.pts_us, tgt);
                end
                else
                begin
                    found = take_newest(w.pts_us, tgt);
                    if (!found)
                        r.event_res = EV_MISSING;
                    else
                    begin
                        lead = tgt - w.time_ns;
                        r.target_lead_ns = lead;
                        newest_pts  = w.pts_us;
                        newest_seen = 1'b1;
                        if ($signed(lead) < $signed({32'd0, lead_floor}))
                            r.event_res = EV_EXPIRED;
                        else if ($signed(lead) > $signed({32'd0, lead_ceiling}))
                            r.event_res = EV_FUTURE;
                        else
                        begin
                            r.action = ACT_SCHEDULE;
                            r.target_time_ns = tgt;
                        end
                    end
                end
            end
            CMD_DISCARD_HANDLE:
            begin
                // lowest matching slot wins, handle zero never matches
                removed = 1'b0;
                if (w.handle_in != '0)
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (!removed && slot_live[i] && slot_handle[i] == w.handle_in)
                        begin
                            slot_live[i] = 1'b0;
                            if (live_count > 0)
                                live_count--;
                            removed = 1'b1;
                        end
            end
            CMD_DISCARD_PTS:
                found = take_newest(w.pts_us, tgt);
            CMD_RESET:
            begin
                // handle counter and registers survive
                clear_slots();
                newest_pts  = '0;
                newest_seen = 1'b0;
            end
            default: ;
        endcase
        r.pending_count = 4'(live_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("frame_presentation_target_table_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: compare each accepted word, then pick the next ready
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t result %s: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (predicted_results.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected result word: expected none, actual %h", $time, result);
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("handle_out", 64'(want.handle_out), 64'(result.handle_out));
                check_field("action", 64'(want.action), 64'(result.action));
                check_field("event_res", 64'(want.event_res), 64'(result.event_res));
                check_field("target_time_ns", want.target_time_ns, result.target_time_ns);
                check_field("target_lead_ns", want.target_lead_ns, result.target_lead_ns);
                check_field("pending_count", 64'(want.pending_count),
                            64'(result.pending_count));
            end
        end
        // sink stalls with a chance of about 27 in a hundred unless no_idle is set
        result_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 27);
    end

    // ------------------------------------------------------------------
    // item side and register port
    // ------------------------------------------------------------------

    // one item word; valid stays high after acceptance until the next call
    // or wait_idle decides, so back to back words never toggle valid in a step
    task automatic send_item(input item_t w);
        if (!no_idle)
            while ($urandom_range(99) < 27)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (!item_ready);
        predicted_results.push_back(predict_table_step(w));
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SUBMIT_LEAD)
            lead_floor = data;
        else if (idx == REG_MAX_FUTURE)
            lead_ceiling = data;
        @(posedge clk);
    endtask

    function automatic item_t make_item(input logic [2:0] cmd, input logic [63:0] pts,
                                        input logic [63:0] tns, input bit sched,
                                        input bit disc, input logic [31:0] hin);
        item_t w;
        w.cmd                = cmd;
        w.pts_us             = pts;
        w.time_ns            = tns;
        w.plan_schedules     = sched;
        w.plan_discontinuity = disc;
        w.handle_in          = hin;
        return w;
    endfunction

    // one of zero, all ones and the two signed extremes, else a random 64-bit value
    function automatic logic [63:0] wide_value();
        case ($urandom_range(5))
            0:       return 64'h0;
            1:       return 64'h7fff_ffff_ffff_ffff;
            2:       return 64'h8000_0000_0000_0000;
            3:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // a lead at, just beyond, far beyond or within the limits of the current register setting
    function automatic longint pick_lead();
        longint lo;
        longint hi;
        lo = longint'({32'd0, lead_floor});
        hi = longint'({32'd0, lead_ceiling});
        case ($urandom_range(9))
            0: return lo;
            1: return hi;
            2: return lo - 1;
            3: return hi + 1;
            8: return lo - 1 - longint'({32'd0, $urandom});
            9: return hi + 1 + longint'({32'd0, $urandom});
            default:
                if (hi >= lo)
                    return lo + longint'({32'd0, $urandom}) % (hi - lo + 1);
                else
                    return lo;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // stores at the timestamp extremes, an unscheduled frame with a stray
    // discontinuity flag, and a discontinuity that empties the table
    task automatic test_prepare_extremes();
        send_item(make_item(CMD_PREPARE, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                            1'b1, 1'b0, '1));
        send_item(make_item(CMD_PREPARE, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                            1'b1, 1'b0, '0));
        send_item(make_item(CMD_PREPARE, 64'd500, 64'd900, 1'b0, 1'b1, '0));
        send_item(make_item(CMD_PREPARE, 64'd1000, 64'd10_000_000, 1'b1, 1'b1, '0));
    endtask

    // scheduled, newest duplicate, expired, future, missing and late frame
    task automatic test_decoded_outcomes();
        send_item(make_item(CMD_PREPARE, 64'd2000, 64'd20_000_000, 1'b1, 1'b0, '0));
        send_item(make_item(CMD_PREPARE, 64'd3000, 64'd30_000_000, 1'b1, 1'b0, '0));
        send_item(make_item(CMD_PREPARE, 64'd4000, 64'd40_000_000, 1'b1, 1'b0, '0));
        send_item(make_item(CMD_PREPARE, 64'd2000, 64'd99, 1'b1, 1'b0, '0));
        send_item(make_item(CMD_DECODED, 64'd1000, 64'd0, 1'b0, 1'b0, '0));
        send_item(make_item(CMD_DECODED, 64'd2000, 64'd0, 1'b0, 1'b0, '0));
        send_item(make_item(CMD_DECODED, 64'd3000, 64'd31_000_000, 1'b0, 1'b0, '0));
        send_item(make_item(CMD_DECODED, 64'd4000, -64'sd20_000_000, 1'b0, 1'b0, '0));
        send_item(make_item(CMD_DECODED, 64'd5000, 64'd0, 1'b0, 1'b0, '0));
        // older duplicate of 2000 is still stored and goes with the drop
        send_item(make_item(CMD_DECODED, 64'd2000, 64'd0, 1'b0, 1'b0, '0));
    endtask

    // removal by handle and by timestamp, hits and misses
    task automatic test_discards();
        send_item(make_item(CMD_PREPARE, 64'd6000, 64'd60_000_000, 1'b1, 1'b0, '0));
        send_item(make_item(CMD_DISCARD_HANDLE, '0, '0, 1'b0, 1'b0, '0));
        send_item(make_item(CMD_DISCARD_HANDLE, '0, '0, 1'b0, 1'b0, handle_ctr - 32'd1));
        send_item(make_item(CMD_PREPARE, 64'd7000, 64'd70_000_000, 1'b1, 1'b0, '0));
        send_item(make_item(CMD_DISCARD_PTS, 64'd7000, '0, 1'b0, 1'b0, '0));
        send_item(make_item(CMD_DISCARD_PTS, 64'd7000, '0, 1'b0, 1'b0, '0));
    endtask

    // reset command keeps the handle counter, spare codes change nothing
    task automatic test_reset_and_spare();
        send_item(make_item(CMD_RESET, '1, '1, 1'b1, 1'b1, '1));
        for (int c = CMD_RESET + 1; c < CMD_SPACE; c++)
            send_item(make_item(3'(c), '1, '1, 1'b1, 1'b1, '1));
    endtask

    // random frame stream under one register setting: mostly prepare then
    // decoded pairs in order, with reordering, discards, resets and noise
    task automatic test_random_stream(input logic [31:0] floor_ns, input logic [31:0] ceil_ns,
                                      input int count, input bit calm);
        item_t w;
        int    pick;
        int    k;
        wait_idle();
        write_register(REG_SUBMIT_LEAD, floor_ns);
        write_register(REG_MAX_FUTURE, ceil_ns);
        no_idle = calm;
        for (int n = 0; n < count; n++)
        begin
            // sender holds off once per phase until the block has drained
            if (n == count / 2)
                wait_idle();
            w = '0;
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                w.cmd                = CMD_PREPARE;
                w.plan_schedules     = ($urandom_range(9) != 0);
                w.plan_discontinuity = ($urandom_range(24) == 0);
                if (w.plan_schedules && w.plan_discontinuity)
                begin
                    // timestamps may restart after a discontinuity
                    pool_pts.delete();
                    pool_tgt.delete();
                    stream_pts -= longint'($urandom_range(200000));
                end
                stream_pts += FRAME_US + longint'($urandom_range(2));
                stream_ns  += FRAME_NS;
                w.pts_us    = stream_pts;
                w.time_ns   = stream_ns;
                w.handle_in = $urandom;
                if (w.plan_schedules)
                begin
                    pool_pts.push_back(stream_pts);
                    pool_tgt.push_back(stream_ns);
                    // the ring overwrites its oldest slot
                    if (pool_pts.size() > TABLE_DEPTH)
                    begin
                        pool_pts.pop_front();
                        pool_tgt.pop_front();
                    end
                end
            end
            else if (pick < 80)
            begin
                w.cmd = CMD_DECODED;
                if (pool_pts.size() != 0 && $urandom_range(9) != 0)
                begin
                    // mostly in order, sometimes a later frame first
                    k = ($urandom_range(6) == 0) ? $urandom_range(pool_pts.size() - 1) : 0;
                    w.pts_us  = pool_pts[k];
                    w.time_ns = pool_tgt[k] - pick_lead();
                    pool_pts.delete(k);
                    pool_tgt.delete(k);
                end
                else
                begin
                    w.pts_us  = stream_pts + longint'($urandom_range(50000)) - 25000;
                    w.time_ns = stream_ns;
                end
            end
            else if (pick < 87)
            begin
                w.cmd = CMD_DISCARD_HANDLE;
                case ($urandom_range(3))
                    0:       w.handle_in = '0;
                    1:       w.handle_in = $urandom;
                    default: w.handle_in = handle_ctr - 32'd1 - 32'($urandom_range(9));
                endcase
            end
            else if (pick < 93)
            begin
                w.cmd = CMD_DISCARD_PTS;
                if (pool_pts.size() != 0 && $urandom_range(3) != 0)
                begin
                    k = $urandom_range(pool_pts.size() - 1);
                    w.pts_us = pool_pts[k];
                    pool_pts.delete(k);
                    pool_tgt.delete(k);
                end
                else
                    w.pts_us = stream_pts - longint'($urandom_range(100000));
            end
            else if (pick < 95)
            begin
                w.cmd = CMD_RESET;
                pool_pts.delete();
                pool_tgt.delete();
            end
            else
            begin
                // noise over the whole field space
                w.cmd                = 3'($urandom_range(CMD_SPACE - 1));
                w.pts_us             = wide_value();
                w.time_ns            = wide_value();
                w.plan_schedules     = 1'($urandom_range(1));
                w.plan_discontinuity = 1'($urandom_range(1));
                w.handle_in          = $urandom;
            end
            send_item(w);
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_table_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs on the reset register values
        test_prepare_extremes();
        test_decoded_outcomes();
        test_discards();
        test_reset_and_spare();

        // register sweep with random traffic, extremes included
        test_random_stream(32'd1_500_000, 32'd50_000_001, 300, 1'b0);
        test_random_stream(32'd0, 32'd3_000_000, 250, 1'b0);
        test_random_stream(32'hffff_ffff, 32'hffff_ffff, 200, 1'b0);
        // long stretch with no idling on either side
        test_random_stream(32'd8_000_000, 32'hffff_ffff, 300, 1'b1);
        // floor above ceiling: nothing can be scheduled
        test_random_stream(32'd4_000_000, 32'd3_000_000, 200, 1'b0);
        test_random_stream(32'd0, 32'd50_000_001, 300, 1'b0);

        wait_idle();
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("frame_presentation_target_table_top: match");
        else
            $display("frame_presentation_target_table_top: mismatch");
        $finish;
    end

endmodule
